// File: hdl/mt64_pkg.sv
// mt64_pkg: shared types, constants and the output tempering function
// for the 64-bit mersenne twister generator
// no dependencies
package mt64_pkg;

    localparam int STATE_WORDS  = 312;
    localparam int TWIST_OFFSET = 156;
    localparam int IDX_W        = $clog2(STATE_WORDS + 1);

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [63:0] SEED_MULT  = 64'd6364136223846793005;
    localparam logic [63:0] MATRIX_A   = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] UPPER_MASK = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] LOWER_MASK = 64'h0000_0000_7FFF_FFFF;

    localparam logic [63:0] TEMPER_D = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TEMPER_B = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [63:0] TEMPER_C = 64'hFFF7_EEE0_0000_0000;

    // head of the request queue as seen by the engine
    typedef struct packed {
        logic valid;
        logic reseed;
    } req_t;

    function automatic logic [63:0] temper(input logic [63:0] w);
        logic [63:0] y;
        y = w;
        y = y ^ ((y >> 29) & TEMPER_D);
        y = y ^ ((y << 17) & TEMPER_B);
        y = y ^ ((y << 37) & TEMPER_C);
        y = y ^ (y >> 43);
        return y;
    endfunction

endpackage

// File: hdl/mt64_front.sv
// mt64_front: input side, takes draw requests into a small queue
// depends on mt64_pkg
module mt64_front #(
    parameter int QUEUE_DEPTH = mt64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_reseed,
    input  logic          pop,
    output mt64_pkg::req_t req
);
    import mt64_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [QUEUE_DEPTH-1:0] flag_reg;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   push, take;

    assign s_ready = (count_reg != FULL_CNT);
    assign push    = s_valid && s_ready;
    assign take    = pop && (count_reg != '0);

    assign req.valid  = (count_reg != '0);
    assign req.reseed = flag_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !take) begin
            count_next = count_reg + 1'b1;
        end else if (take && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            flag_reg[wr_ptr_reg] <= s_reseed;
        end
    end

endmodule

// File: hdl/mt64_engine.sv
// mt64_engine: state memory, seeding, twist and tempered output register
// depends on mt64_pkg
module mt64_engine (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [63:0]    cfg_wr_data,
    input  mt64_pkg::req_t req,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [63:0]    m_data
);
    import mt64_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] N_IDX    = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0] OFS_IDX  = IDX_W'(TWIST_OFFSET);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_SEED_W0  = 12'b0000_0000_0010,
        ST_SEED_MIX = 12'b0000_0000_0100,
        ST_SEED_M0  = 12'b0000_0000_1000,
        ST_SEED_M1  = 12'b0000_0001_0000,
        ST_SEED_M2  = 12'b0000_0010_0000,
        ST_SEED_WR  = 12'b0000_0100_0000,
        ST_TW_PRE   = 12'b0000_1000_0000,
        ST_TW_LD    = 12'b0001_0000_0000,
        ST_TW_RD    = 12'b0010_0000_0000,
        ST_TW_WR    = 12'b0100_0000_0000,
        ST_DRAW     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] twister_mem [STATE_WORDS];

    logic [63:0]      seed_reg;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             busy_reg, busy_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [63:0]      prev_reg, prev_next;
    logic [63:0]      mix_reg, mix_next;
    logic [63:0]      pp_reg, pp_next;
    logic [31:0]      cross_reg, cross_next;
    logic [63:0]      cur_reg, cur_next;
    logic [63:0]      rd_a_reg, rd_b_reg;
    logic             m_valid_reg, m_valid_next;
    logic [63:0]      m_data_reg, m_data_next;

    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, rd_addr_a, rd_addr_b;
    logic [63:0]      mem_wdata;

    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;
    logic [IDX_W-1:0] nxt_idx, far_idx;
    logic [63:0]      tw_x, tw_v, seed_w;
    logic             out_free;

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign nxt_idx = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign far_idx = (idx_reg < OFS_IDX) ? idx_reg + OFS_IDX : idx_reg - OFS_IDX;

    assign tw_x   = (cur_reg & UPPER_MASK) | (rd_a_reg & LOWER_MASK);
    assign tw_v   = rd_b_reg ^ (tw_x >> 1) ^ (tw_x[0] ? MATRIX_A : 64'd0);
    assign seed_w = pp_reg + {cross_reg, 32'd0} + 64'(idx_reg);

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = (state_reg == ST_IDLE) && req.valid;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        busy_next    = busy_reg;
        rd_pend_next = 1'b0;
        prev_next    = prev_reg;
        mix_next     = mix_reg;
        pp_next      = pp_reg;
        cross_next   = cross_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = seed_w;
        mem_re       = 1'b0;
        rd_addr_a    = nxt_idx;
        rd_addr_b    = far_idx;
        mul_a        = mix_reg[31:0];
        mul_b        = SEED_MULT[31:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (req.valid) begin
                    busy_next = 1'b1;
                    if (req.reseed) begin
                        state_next = ST_SEED_W0;
                    end else if (pos_reg >= N_IDX) begin
                        state_next = ST_TW_PRE;
                    end else begin
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_SEED_W0: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = seed_reg;
                prev_next  = seed_reg;
                idx_next   = IDX_W'(1);
                state_next = ST_SEED_MIX;
            end
            ST_SEED_MIX: begin
                mix_next   = prev_reg ^ (prev_reg >> 62);
                state_next = ST_SEED_M0;
            end
            ST_SEED_M0: begin
                pp_next    = mul_p;
                state_next = ST_SEED_M1;
            end
            ST_SEED_M1: begin
                mul_b      = SEED_MULT[63:32];
                cross_next = mul_p[31:0];
                state_next = ST_SEED_M2;
            end
            ST_SEED_M2: begin
                mul_a      = mix_reg[63:32];
                cross_next = cross_reg + mul_p[31:0];
                state_next = ST_SEED_WR;
            end
            ST_SEED_WR: begin
                mem_we    = 1'b1;
                prev_next = seed_w;
                if (idx_reg == LAST_IDX) begin
                    pos_next   = N_IDX;
                    state_next = busy_reg ? ST_TW_PRE : ST_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SEED_MIX;
                end
            end
            ST_TW_PRE: begin
                mem_re     = 1'b1;
                rd_addr_a  = '0;
                state_next = ST_TW_LD;
            end
            ST_TW_LD: begin
                cur_next   = rd_a_reg;
                idx_next   = '0;
                state_next = ST_TW_RD;
            end
            ST_TW_RD: begin
                mem_re     = 1'b1;
                state_next = ST_TW_WR;
            end
            ST_TW_WR: begin
                // in-place update, word i+1 is still the old value
                mem_we    = 1'b1;
                mem_wdata = tw_v;
                cur_next  = rd_a_reg;
                if (idx_reg == LAST_IDX) begin
                    pos_next   = '0;
                    state_next = ST_DRAW;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TW_RD;
                end
            end
            ST_DRAW: begin
                // first cycle issues the read, later cycles wait for room
                if (!rd_pend_reg) begin
                    mem_re       = 1'b1;
                    rd_addr_a    = pos_reg;
                    rd_pend_next = 1'b1;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = temper(rd_a_reg);
                    pos_next     = pos_reg + 1'b1;
                    busy_next    = 1'b0;
                    state_next   = ST_IDLE;
                end else begin
                    rd_pend_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SEED_W0;
            seed_reg    <= '0;
            pos_reg     <= N_IDX;
            idx_reg     <= '0;
            busy_reg    <= 1'b0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            idx_reg     <= idx_next;
            busy_reg    <= busy_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg   <= prev_next;
        mix_reg    <= mix_next;
        pp_reg     <= pp_next;
        cross_reg  <= cross_next;
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            twister_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_a_reg <= twister_mem[rd_addr_a];
            rd_b_reg <= twister_mem[rd_addr_b];
        end
    end

endmodule

// File: hdl/mt64_random_generator.sv
// mt64_random_generator: 64-bit mersenne twister, top level
// depends on mt64_pkg, mt64_front, mt64_engine
// with no twist due, an accepted word is queued and popped by the idle engine, which
// reads state memory and tempers it into the output register once that has room;
//   one word served at a time; every 312 words add a twist (read, write per word)
// a reseed adds seeding (five steps per state word) and then the twist
// reset: synchronous; seed clears to zero and the state is seeded from it,
//   requests queue up meanwhile
module mt64_random_generator #(
    parameter int QUEUE_DEPTH = mt64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] reseed, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] random_word
);
    import mt64_pkg::*;

    req_t req;
    logic pop;

    mt64_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_reseed (s_axis_tdata[0]),
        .pop      (pop),
        .req      (req)
    );

    mt64_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .pop         (pop),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_data      (m_axis_tdata)
    );

endmodule
